[hw/rtl/srsw_pkg.sv]
`default_nettype none
package srsw_pkg;

	localparam int SLOTS      = 32;
	localparam int TIMER_BITS = 20;

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int SEQ_W   = 31;
	localparam int ENTRY_W = 2 + TIMER_BITS;

	localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_ACK   = 2'd1;
	localparam logic [1:0] CMD_OFFER = 2'd2;

	localparam logic CFG_WINDOW  = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'd0,
		ST_WAIT  = 2'd1,
		ST_ACKED = 2'd2,
		ST_DONE  = 2'd3
	} slot_st_t;

	typedef enum logic [2:0] {
		ACT_NONE     = 3'd0,
		ACT_SEND     = 3'd1,
		ACT_RESEND   = 3'd2,
		ACT_REFUSED  = 3'd3,
		ACT_IGNORED  = 3'd4,
		ACT_COMPLETE = 3'd5
	} act_t;

	// A push queues one result; a close ends the current request.
	typedef struct packed {
		logic             push;
		logic             close;
		act_t             action;
		logic [SEQ_W-1:0] seq;
	} res_req_t;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W:0] r;
		r = {1'b0, s} + (SLOT_W+1)'(1);
		if (r >= (SLOT_W+1)'(SLOTS)) begin
			r = '0;
		end
		return r[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] b,
		input logic [SLOT_W-1:0] off);
		logic [SLOT_W:0] r;
		r = {1'b0, b} + {1'b0, off};
		if (r >= (SLOT_W+1)'(SLOTS)) begin
			r = r - (SLOT_W+1)'(SLOTS);
		end
		return r[SLOT_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/srsw_slot_ram.sv]
`default_nettype none
module srsw_slot_ram #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 22,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/srsw_result_buf.sv]
`default_nettype none
module srsw_result_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire srsw_pkg::res_req_t  req,
	output logic                     pending,
	output logic                     result_strobe,
	output logic [2:0]               action,
	output logic [srsw_pkg::SEQ_W-1:0] seq_number,
	output logic                     last
);
	import srsw_pkg::*;

	logic             pend_v_q;
	act_t             pend_act_q;
	logic [SEQ_W-1:0] pend_seq_q;
	logic             strobe_q;
	act_t             act_q;
	logic [SEQ_W-1:0] seq_q;
	logic             last_q;

	// One result is held back so that the last one of a request can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (req.push) begin
				strobe_q <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (req.close) begin
				strobe_q <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.push) begin
			act_q      <= pend_act_q;
			seq_q      <= pend_seq_q;
			last_q     <= 1'b0;
			pend_act_q <= req.action;
			pend_seq_q <= req.seq;
		end else if (req.close) begin
			act_q  <= pend_act_q;
			seq_q  <= pend_seq_q;
			last_q <= 1'b1;
		end
	end

	assign pending       = pend_v_q;
	assign result_strobe = strobe_q;
	assign action        = act_q;
	assign seq_number    = seq_q;
	assign last          = last_q;

endmodule
`default_nettype wire

[hw/rtl/selective_repeat_sender_window.sv]
`default_nettype none
// An offer goes from acceptance through a close state back to idle; an ack in the window
// first writes its slot, and a tick walks the outstanding slots, one slot per cycle, then
// passes a tail state before the close. Results follow on one-cycle strobes; the last result of a
// request is on the ports in the first cycle with busy low, when the next may be accepted.
// Asynchronous reset empties the window, restores window_limit 20 and timeout_ticks 100;
// the slot memory itself is not cleared. The receiver cannot stall.
module selective_repeat_sender_window (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  command,
	input  wire logic signed [31:0]          ack_number,
	input  wire logic                        is_final,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [19:0]                 cfg_data,
	output logic                             result_strobe,
	output logic [2:0]                       action,
	output logic [srsw_pkg::SEQ_W-1:0]       seq_number,
	output logic                             last
);
	import srsw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACK_WR,
		S_WALK,
		S_TAIL,
		S_CLOSE
	} state_t;

	state_t            state_q;
	logic [5:0]        window_limit_q;
	logic [19:0]       timeout_ticks_q;
	logic [SEQ_W-1:0]  base_q;
	logic [SEQ_W-1:0]  next_q;
	logic [SLOT_W-1:0] base_slot_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic              final_seen_q;
	logic              done_q;
	logic [SLOT_W-1:0] ack_slot_q;
	logic [SLOT_W-1:0] walk_slot_q;
	logic [SEQ_W-1:0]  walk_seq_q;
	logic [CNT_W-1:0]  remaining_q;
	logic              prefix_q;

	logic                  accept;
	logic [31:0]           win32;
	logic [SEQ_W-1:0]      eff_win;
	logic [31:0]           to32;
	logic [TIMER_BITS-1:0] eff_to;
	logic [SEQ_W-1:0]      used;
	logic                  refuse;
	logic [SEQ_W-1:0]      ack_seq;
	logic                  ack_in;
	logic [SLOT_W-1:0]     ack_slot;

	logic                  mem_we;
	logic [SLOT_W-1:0]     mem_waddr;
	logic [ENTRY_W-1:0]    mem_wdata;
	logic [SLOT_W-1:0]     mem_raddr;
	logic [ENTRY_W-1:0]    mem_rdata;
	slot_st_t              rd_st;
	logic [TIMER_BITS-1:0] rd_tm;

	slot_st_t              new_st;
	logic [TIMER_BITS-1:0] new_tm;
	logic                  resend;
	logic                  complete;

	res_req_t req;
	logic     pending;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		win32 = 32'(window_limit_q);
		if (win32 == 32'd0) begin
			win32 = 32'd1;
		end else if (win32 > 32'(SLOTS)) begin
			win32 = 32'(SLOTS);
		end
		eff_win = win32[SEQ_W-1:0];
	end

	always_comb begin
		to32   = 32'(timeout_ticks_q);
		eff_to = to32[TIMER_BITS-1:0];
		if (eff_to == '0) begin
			eff_to = TIMER_BITS'(1);
		end
	end

	assign used   = next_q - base_q;
	assign refuse = done_q || final_seen_q || (used >= eff_win) || (next_q == SEQ_MAX);

	assign ack_seq  = ack_number[SEQ_W-1:0];
	assign ack_in   = !ack_number[31] && (ack_seq >= base_q) && (ack_seq < next_q);
	assign ack_slot = slot_add(base_slot_q, SLOT_W'(ack_seq - base_q));

	assign rd_st = slot_st_t'(mem_rdata[ENTRY_W-1:TIMER_BITS]);
	assign rd_tm = mem_rdata[TIMER_BITS-1:0];

	// Countdown of the slot that the walk has just read.
	always_comb begin
		new_st = rd_st;
		new_tm = rd_tm;
		resend = 1'b0;
		if (rd_st == ST_WAIT || rd_st == ST_ACKED) begin
			if (rd_tm > TIMER_BITS'(1)) begin
				new_tm = rd_tm - TIMER_BITS'(1);
			end else if (rd_st == ST_ACKED) begin
				new_st = ST_DONE;
				new_tm = '0;
			end else begin
				new_tm = eff_to;
				resend = 1'b1;
			end
		end
	end

	assign complete = final_seen_q && (base_q == next_q);

	always_comb begin
		req        = '0;
		req.action = ACT_NONE;
		mem_we     = 1'b0;
		mem_waddr  = walk_slot_q;
		mem_wdata  = {new_st, new_tm};
		mem_raddr  = base_slot_q;
		case (state_q)
			S_IDLE: begin
				if (command == CMD_ACK) begin
					mem_raddr = ack_slot;
				end
				if (accept) begin
					if (command == CMD_OFFER) begin
						req.push   = 1'b1;
						req.seq    = next_q;
						if (refuse) begin
							req.action = ACT_REFUSED;
						end else begin
							req.action = ACT_SEND;
							mem_we     = 1'b1;
							mem_waddr  = next_slot_q;
							mem_wdata  = {ST_WAIT, eff_to};
						end
					end else if (command == CMD_ACK) begin
						req.push   = 1'b1;
						req.action = ack_in ? ACT_NONE : ACT_IGNORED;
						req.seq    = ack_number[31] ? '0 : ack_seq;
					end else if (done_q) begin
						req.push   = 1'b1;
						req.action = ACT_NONE;
						req.seq    = '0;
					end
				end
			end
			S_ACK_WR: begin
				mem_waddr = ack_slot_q;
				mem_wdata = {ST_ACKED, rd_tm};
				mem_we    = (rd_st == ST_WAIT);
			end
			S_WALK: begin
				mem_raddr  = slot_inc(walk_slot_q);
				mem_we     = 1'b1;
				req.push   = resend;
				req.action = ACT_RESEND;
				req.seq    = walk_seq_q;
			end
			S_TAIL: begin
				if (complete) begin
					req.push   = 1'b1;
					req.action = ACT_COMPLETE;
					req.seq    = next_q - SEQ_W'(1);
				end else if (!pending) begin
					req.push   = 1'b1;
					req.action = ACT_NONE;
					req.seq    = base_q;
				end
			end
			S_CLOSE: begin
				req.close = 1'b1;
			end
			default: begin
				req.close = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_limit_q  <= 6'd20;
			timeout_ticks_q <= 20'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW:  window_limit_q  <= cfg_data[5:0];
				CFG_TIMEOUT: timeout_ticks_q <= cfg_data;
				default:     window_limit_q  <= window_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			next_q       <= '0;
			base_slot_q  <= '0;
			next_slot_q  <= '0;
			final_seen_q <= 1'b0;
			done_q       <= 1'b0;
			prefix_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_OFFER) begin
							state_q <= S_CLOSE;
							if (!refuse) begin
								next_q      <= next_q + SEQ_W'(1);
								next_slot_q <= slot_inc(next_slot_q);
								if (is_final) begin
									final_seen_q <= 1'b1;
								end
							end
						end else if (command == CMD_ACK) begin
							state_q <= ack_in ? S_ACK_WR : S_CLOSE;
						end else if (done_q) begin
							state_q <= S_CLOSE;
						end else begin
							prefix_q <= 1'b1;
							state_q  <= (used == '0) ? S_TAIL : S_WALK;
						end
					end
				end
				S_ACK_WR: begin
					state_q <= S_CLOSE;
				end
				S_WALK: begin
					// The base follows the walk as long as every slot behind it is done.
					if (prefix_q && new_st == ST_DONE) begin
						base_q      <= base_q + SEQ_W'(1);
						base_slot_q <= slot_inc(base_slot_q);
					end else begin
						prefix_q <= 1'b0;
					end
					if (remaining_q == CNT_W'(1)) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (complete) begin
						done_q <= 1'b1;
					end
					state_q <= S_CLOSE;
				end
				S_CLOSE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			ack_slot_q  <= ack_slot;
			walk_slot_q <= base_slot_q;
			walk_seq_q  <= base_q;
			remaining_q <= CNT_W'(used);
		end else if (state_q == S_WALK) begin
			walk_slot_q <= slot_inc(walk_slot_q);
			walk_seq_q  <= walk_seq_q + SEQ_W'(1);
			remaining_q <= remaining_q - CNT_W'(1);
		end
	end

	srsw_slot_ram #(
		.DEPTH (SLOTS),
		.WIDTH (ENTRY_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	srsw_result_buf u_result_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.pending       (pending),
		.result_strobe (result_strobe),
		.action        (action),
		.seq_number    (seq_number),
		.last          (last)
	);

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pending)
		else $error("result still held while idle");
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= SEQ_W'(SLOTS))
		else $error("window wider than the slot table");
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (remaining_q != '0))
		else $error("walk runs with no slot left");
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (base_q == next_q))
		else $error("transfer done with packets outstanding");
	a_close_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) |=> (result_strobe && last))
		else $error("request closed without a last result");
`endif

endmodule
`default_nettype wire

[sim/arq_window_checker.sv]
module arq_window_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [1:0]                  command,
	input  wire logic [31:0]                 ack_number,
	input  wire logic                        is_final,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [19:0]                 cfg_data,
	input  wire logic                        result_strobe,
	input  wire logic [2:0]                  action,
	input  wire logic [srsw_pkg::SEQ_W-1:0]  seq_number,
	input  wire logic                        last,
	output int                               errors,
	output int                               pending,
	output logic [31:0]                      obs_base,
	output logic [31:0]                      obs_next
);
	import srsw_pkg::*;

	typedef struct {
		act_t             action;
		logic [SEQ_W-1:0] seq;
		logic             last;
	} arq_result_t;

	arq_result_t want_results[$];
	arq_result_t got;

	slot_st_t              slot_state [SLOTS];
	logic [TIMER_BITS-1:0] slot_count [SLOTS];
	logic [31:0]           base_seq;
	logic [31:0]           next_seq;
	logic                  final_offered;
	logic                  all_done;
	logic [5:0]            window_reg;
	logic [19:0]           timeout_reg;
	int                    err_count = 0;

	function automatic logic [TIMER_BITS-1:0] timeout_now();
		logic [TIMER_BITS-1:0] t;
		t = timeout_reg[TIMER_BITS-1:0];
		return (t == '0) ? TIMER_BITS'(1) : t;
	endfunction

	task automatic note(input act_t act, input logic [31:0] seq);
		arq_result_t r;
		r.action = act;
		r.seq = seq[SEQ_W-1:0];
		r.last = 1'b0;
		want_results = {want_results, r};
	endtask

	task automatic advance_window(input logic [1:0] cmd, input logic [31:0] raw,
		input logic fin);
		logic [31:0] used;
		logic [31:0] count;
		logic [31:0] sq;
		logic [31:0] win;
		int slot;
		int made;
		int i;
		made = want_results.size();
		case (cmd)
			CMD_OFFER: begin
				used = next_seq - base_seq;
				win = (window_reg == 0) ? 32'd1 : (window_reg > SLOTS) ? SLOTS : window_reg;
				if (all_done || final_offered || used >= win || next_seq >= {1'b0, SEQ_MAX}) begin
					note(ACT_REFUSED, next_seq);
				end else begin
					slot = next_seq % SLOTS;
					slot_state[slot] = ST_WAIT;
					slot_count[slot] = timeout_now();
					if (fin) begin
						final_offered = 1'b1;
					end
					note(ACT_SEND, next_seq);
					next_seq++;
				end
			end
			CMD_ACK: begin
				if (raw[31]) begin
					note(ACT_IGNORED, 32'd0);
				end else if (raw < base_seq || raw >= next_seq) begin
					note(ACT_IGNORED, raw);
				end else begin
					slot = raw % SLOTS;
					if (slot_state[slot] == ST_WAIT) begin
						slot_state[slot] = ST_ACKED;
					end
					note(ACT_NONE, raw);
				end
			end
			default: begin
				if (all_done) begin
					note(ACT_NONE, 32'd0);
				end else begin
					count = next_seq - base_seq;
					if (count > SLOTS) begin
						count = SLOTS;
					end
					for (i = 0; i < count; i++) begin
						sq = base_seq + i;
						slot = sq % SLOTS;
						if (slot_state[slot] == ST_WAIT || slot_state[slot] == ST_ACKED) begin
							if (slot_count[slot] > 1) begin
								slot_count[slot]--;
							end else if (slot_state[slot] == ST_ACKED) begin
								slot_count[slot] = '0;
								slot_state[slot] = ST_DONE;
							end else begin
								slot_count[slot] = timeout_now();
								note(ACT_RESEND, sq);
							end
						end
					end
					while (base_seq < next_seq && slot_state[base_seq % SLOTS] == ST_DONE) begin
						slot_state[base_seq % SLOTS] = ST_EMPTY;
						base_seq++;
					end
					if (final_offered && base_seq == next_seq) begin
						all_done = 1'b1;
						note(ACT_COMPLETE, next_seq - 1);
					end
					// A tick that produced nothing else reports the window base.
					if (want_results.size() == made) begin
						note(ACT_NONE, base_seq);
					end
				end
			end
		endcase
		want_results[want_results.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				slot_state[k] = ST_EMPTY;
				slot_count[k] = '0;
			end
			base_seq = '0;
			next_seq = '0;
			final_offered = 1'b0;
			all_done = 1'b0;
			window_reg = 6'd20;
			timeout_reg = 20'd100;
			want_results.delete();
			errors <= err_count;
			pending <= 0;
			obs_base <= '0;
			obs_next <= '0;
		end else begin
			if (result_strobe) begin
				if (want_results.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, expected none, got action %0d seq %0d last %0b",
						$time, action, seq_number, last);
				end else begin
					got = want_results.pop_front();
					if (action !== got.action || seq_number !== got.seq || last !== got.last) begin
						err_count++;
						$display("%0t: expected action %0d seq %0d last %0b, got action %0d seq %0d last %0b",
							$time, got.action, got.seq, got.last, action, seq_number, last);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_WINDOW) begin
					window_reg = cfg_data[5:0];
				end else begin
					timeout_reg = cfg_data;
				end
			end
			if (start && !busy) begin
				advance_window(command, ack_number, is_final);
			end
			errors <= err_count;
			pending <= want_results.size();
			obs_base <= base_seq;
			obs_next <= next_seq;
		end
	end

endmodule

[sim/testbench.sv]
module testbench;
	import srsw_pkg::*;

	// Command 3 is not defined; the block treats it as a tick.
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic [1:0]        command;
	logic signed [31:0] ack_number;
	logic              is_final;
	logic              cfg_we;
	logic              cfg_index;
	logic [19:0]       cfg_data;
	logic              busy;
	logic              result_strobe;
	logic [2:0]        action;
	logic [SEQ_W-1:0]  seq_number;
	logic              last;

	int                errors;
	int                pending;
	logic [31:0]       obs_base;
	logic [31:0]       obs_next;
	bit                calm;

	selective_repeat_sender_window dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.ack_number(ack_number),
		.is_final(is_final),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.action(action),
		.seq_number(seq_number),
		.last(last)
	);

	arq_window_checker window_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.ack_number(ack_number),
		.is_final(is_final),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.action(action),
		.seq_number(seq_number),
		.last(last),
		.errors(errors),
		.pending(pending),
		.obs_base(obs_base),
		.obs_next(obs_next)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic issue(input logic [1:0] cmd, input logic [31:0] num, input logic fin);
		if (!calm && $urandom_range(99) < 11) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		ack_number <= num;
		is_final <= fin;
		do @(posedge clk); while (busy);
	endtask

	// Waits until the block is idle and every predicted result has come out.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		int r;
		int pick;
		logic [31:0] num;
		logic [31:0] span;
		logic fin;
		r = $urandom_range(99);
		num = $urandom();
		fin = 1'($urandom_range(1));
		span = obs_next - obs_base;
		if (r < 36) begin
			issue(CMD_OFFER, num, 1'b0);
		end else if (r < 66) begin
			pick = $urandom_range(9);
			// Most acks fall inside the window; the rest hit its edges or are junk.
			if (pick <= 5) begin
				num = obs_base + ((span == 0) ? 32'd0 : $urandom_range(span - 1));
			end else if (pick == 6) begin
				num = obs_next;
			end else if (pick == 7) begin
				num = obs_base - 1;
			end else if (pick == 9) begin
				num[31] = 1'b1;
			end
			issue(CMD_ACK, num, fin);
		end else if (r < 97) begin
			issue(CMD_TICK, num, fin);
		end else begin
			issue(CMD_SPARE, num, fin);
		end
	endtask

	task automatic random_phase(input logic [19:0] win, input logic [19:0] tmo, input int count,
		input bit quiet);
		settle();
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_TIMEOUT, tmo);
		calm = quiet;
		repeat (count) random_item();
	endtask

	// Must follow settle() so that the observed window is current.
	task automatic ack_outstanding();
		logic [31:0] seq;
		logic [31:0] stop;
		seq = obs_base;
		stop = obs_next;
		while (seq != stop) begin
			issue(CMD_ACK, seq, 1'($urandom_range(1)));
			seq++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_TICK;
		ack_number = '0;
		is_final = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WINDOW;
		cfg_data = '0;
		calm = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing is outstanding yet, so every ack is outside the window.
		issue(CMD_TICK, 32'd0, 1'b0);
		issue(CMD_ACK, 32'd0, 1'b1);
		issue(CMD_ACK, 32'h8000_0000, 1'b0);
		issue(CMD_ACK, 32'h7FFF_FFFF, 1'b0);
		issue(CMD_ACK, 32'hFFFF_FFFF, 1'b1);
		issue(CMD_SPARE, 32'h1234_5678, 1'b1);

		// Zero in both registers means a window of one and a one-tick timeout.
		settle();
		write_reg(CFG_WINDOW, 20'd0);
		write_reg(CFG_TIMEOUT, 20'd0);
		issue(CMD_OFFER, 32'd0, 1'b0);
		issue(CMD_OFFER, 32'd0, 1'b0);
		issue(CMD_ACK, 32'd0, 1'b0);
		issue(CMD_TICK, 32'd0, 1'b0);
		issue(CMD_OFFER, 32'd0, 1'b0);
		issue(CMD_TICK, 32'd0, 1'b0);
		issue(CMD_ACK, 32'd1, 1'b0);
		issue(CMD_ACK, 32'd1, 1'b0);
		issue(CMD_ACK, 32'd2, 1'b0);
		issue(CMD_TICK, 32'd0, 1'b0);
		issue(CMD_TICK, 32'd0, 1'b0);

		random_phase(20'd4, 20'd3, 40, 1'b0);
		random_phase(20'd32, 20'd5, 45, 1'b1);
		// Only the low six bits of the data reach the window register.
		random_phase(20'hFFFC1, 20'd1, 30, 1'b0);
		random_phase(20'd63, 20'd8, 45, 1'b0);
		random_phase(20'd12, 20'd2, 40, 1'b0);
		random_phase(20'($urandom_range(32, 1)), 20'($urandom_range(6, 1)), 35, 1'b0);

		// Drain the window, then send a short transfer with the final marker.
		settle();
		write_reg(CFG_WINDOW, 20'd8);
		write_reg(CFG_TIMEOUT, 20'd2);
		ack_outstanding();
		repeat (12) issue(CMD_TICK, $urandom(), 1'($urandom_range(1)));
		settle();
		repeat (3) issue(CMD_OFFER, $urandom(), 1'b0);
		issue(CMD_OFFER, $urandom(), 1'b1);
		issue(CMD_OFFER, $urandom(), 1'b0);
		settle();
		ack_outstanding();
		repeat (12) issue(CMD_TICK, $urandom(), 1'($urandom_range(1)));

		// After completion the block refuses and ignores everything.
		settle();
		write_reg(CFG_WINDOW, 20'd32);
		write_reg(CFG_TIMEOUT, 20'hFFFFF);
		issue(CMD_OFFER, 32'd0, 1'b1);
		issue(CMD_ACK, 32'd0, 1'b0);
		issue(CMD_ACK, obs_next - 1, 1'b0);
		issue(CMD_TICK, 32'd0, 1'b0);
		issue(CMD_SPARE, 32'd0, 1'b0);

		settle();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
